@@ sv/assert_macros.svh @@
// ============================================================================
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ sv/ssps_pkg.sv @@
// ============================================================================
// ssps_pkg
// Types, codes and sector tables of the single-shunt sampler.
// ============================================================================
package ssps_pkg;

    localparam int ADC_BITS  = 12;
    localparam int DUTY_BITS = 16;
    localparam int SHIFT_BITS = 17;
    localparam int CUR_BITS  = 14;

    localparam logic FUNC_PWM    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] WIN_FIRST  = 2'b01;
    localparam logic [1:0] WIN_SECOND = 2'b10;
    localparam logic [1:0] WIN_BOTH   = 2'b11;
    localparam logic [1:0] WIN_NONE   = 2'b00;

    localparam logic [1:0] CFG_PWM_PERIOD     = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_DELAY   = 2'd1;
    localparam logic [1:0] CFG_MIN_WINDOW     = 2'd2;
    localparam logic [1:0] CFG_CURRENT_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        PH_U = 2'd0,
        PH_V = 2'd1,
        PH_W = 2'd2
    } phase_t;

    typedef logic [DUTY_BITS-1:0]         duty_t;
    typedef logic signed [SHIFT_BITS-1:0] shift_t;
    typedef logic signed [CUR_BITS-1:0]   cur_t;
    typedef logic [ADC_BITS-1:0]          adc_t;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [4:0] pad;
        adc_t       adc_second;
        adc_t       adc_first;
        duty_t      duty_w;
        duty_t      duty_v;
        duty_t      duty_u;
        logic [2:0] sector;
    } in_item_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic       pad;
        cur_t       current_w;
        cur_t       current_v;
        cur_t       current_u;
        logic [1:0] window_mode;
        duty_t      trigger_second;
        duty_t      trigger_first;
        shift_t     shift_w;
        shift_t     shift_v;
        shift_t     shift_u;
        duty_t      adj_duty_w;
        duty_t      adj_duty_v;
        duty_t      adj_duty_u;
    } out_item_t;

    // in sel_max, sel_min and sel_mid, sector 0 and 7 behave as sector 6
    function automatic phase_t sel_max(input logic [2:0] s);
        phase_t p;
        unique case (s)
            3'd2, 3'd3: p = PH_V;
            3'd4, 3'd5: p = PH_W;
            default:    p = PH_U;
        endcase
        return p;
    endfunction

    function automatic phase_t sel_min(input logic [2:0] s);
        phase_t p;
        unique case (s)
            3'd1, 3'd2: p = PH_W;
            3'd3, 3'd4: p = PH_U;
            default:    p = PH_V;
        endcase
        return p;
    endfunction

    function automatic phase_t sel_mid(input logic [2:0] s);
        phase_t p;
        unique case (s)
            3'd1, 3'd4: p = PH_V;
            3'd2, 3'd5: p = PH_U;
            default:    p = PH_W;
        endcase
        return p;
    endfunction

    function automatic phase_t rd_first(input logic [2:0] s);
        phase_t p;
        unique case (s)
            3'd1, 3'd2: p = PH_W;
            3'd5, 3'd6: p = PH_V;
            default:    p = PH_U;
        endcase
        return p;
    endfunction

    function automatic phase_t rd_second(input logic [2:0] s);
        phase_t p;
        unique case (s)
            3'd2, 3'd3: p = PH_V;
            3'd4, 3'd5: p = PH_W;
            default:    p = PH_U;
        endcase
        return p;
    endfunction

endpackage

@@ sv/ssps_pwm_calc.sv @@
// ============================================================================
// ssps_pwm_calc
// Phase shift rules, ADC trigger points and window mode for a PWM update.
// ============================================================================
module ssps_pwm_calc #(
    parameter int EDGE_WIDTH = 50,
    parameter int TIMER_BITS = 16
) (
    input  logic [2:0]             sector,
    input  ssps_pkg::duty_t        duty_u,
    input  ssps_pkg::duty_t        duty_v,
    input  ssps_pkg::duty_t        duty_w,
    input  logic [15:0]            pwm_period,
    input  logic [15:0]            sample_delay,
    input  logic [15:0]            min_window,
    output ssps_pkg::duty_t        adj_duty_u,
    output ssps_pkg::duty_t        adj_duty_v,
    output ssps_pkg::duty_t        adj_duty_w,
    output ssps_pkg::shift_t       shift_u,
    output ssps_pkg::shift_t       shift_v,
    output ssps_pkg::shift_t       shift_w,
    output ssps_pkg::duty_t        trigger_first,
    output ssps_pkg::duty_t        trigger_second,
    output logic [1:0]             window_mode
);
    import ssps_pkg::*;

    localparam int CW = 19;
    localparam logic signed [CW-1:0] EW = CW'(EDGE_WIDTH);
    localparam logic [DUTY_BITS-1:0] TMASK =
        DUTY_BITS'((17'd1 << TIMER_BITS) - 17'd1);

    phase_t imax;
    phase_t imin;
    phase_t imid;

    logic signed [CW-1:0] dmax;
    logic signed [CW-1:0] dmin;
    logic signed [CW-1:0] dmid;
    logic signed [CW-1:0] per;
    logic signed [CW-1:0] half;
    logic signed [CW-1:0] win;
    logic signed [CW-1:0] nmax;
    logic signed [CW-1:0] nmin;
    logic signed [CW-1:0] nmid;
    logic signed [CW-1:0] shmax;
    logic signed [CW-1:0] shmin;
    logic signed [CW-1:0] shmid;
    logic signed [CW-1:0] tsum_first;
    logic signed [CW-1:0] tsum_second;
    logic [1:0]           mode;

    function automatic duty_t pick(input phase_t p, input duty_t u, input duty_t v,
                                   input duty_t w);
        duty_t r;
        unique case (p)
            PH_V:    r = v;
            PH_W:    r = w;
            default: r = u;
        endcase
        return r;
    endfunction

    function automatic logic signed [CW-1:0] place(input phase_t p,
        input logic signed [CW-1:0] vmin, input logic signed [CW-1:0] vmax,
        input logic signed [CW-1:0] vmid);
        logic signed [CW-1:0] r;
        if (p == imin)
            r = vmin;
        else if (p == imax)
            r = vmax;
        else
            r = vmid;
        return r;
    endfunction

    assign imax = sel_max(sector);
    assign imin = sel_min(sector);
    assign imid = sel_mid(sector);

    assign dmax = $signed({3'b000, pick(imax, duty_u, duty_v, duty_w)});
    assign dmin = $signed({3'b000, pick(imin, duty_u, duty_v, duty_w)});
    assign dmid = $signed({3'b000, pick(imid, duty_u, duty_v, duty_w)});
    assign per  = $signed({3'b000, pwm_period});
    assign half = $signed({4'b0000, pwm_period[15:1]});
    assign win  = $signed({3'b000, min_window});

    always_comb
    begin
        if (EW < dmin)
        begin
            shmin = EW - dmin;
            nmin  = EW;
        end
        else
        begin
            shmin = '0;
            nmin  = dmin;
        end

        // max at or below half period: shift reported, duty kept
        priority if (dmax <= half)
        begin
            shmax = dmax - EW;
            nmax  = dmax;
        end
        else if (per - EW > dmax)
        begin
            shmax = per - EW - dmax;
            nmax  = per - EW;
        end
        else
        begin
            shmax = '0;
            nmax  = dmax;
        end

        if (dmid <= half)
        begin
            shmid = (half - dmid < dmid) ? half - dmid : dmid;
            nmid  = dmid + shmid;
            mode  = WIN_SECOND | ((nmid - nmin > win) ? WIN_FIRST : WIN_NONE);
        end
        else
        begin
            shmid = (dmid - half < per - dmid) ? half - dmid : dmid - per;
            nmid  = dmid + shmid;
            mode  = WIN_FIRST | ((nmax - nmid > win) ? WIN_SECOND : WIN_NONE);
        end
    end

    assign tsum_first  = nmin + $signed({3'b000, sample_delay});
    assign tsum_second = nmid + $signed({3'b000, sample_delay});

    always_comb
    begin
        adj_duty_u = DUTY_BITS'(place(PH_U, nmin, nmax, nmid));
        adj_duty_v = DUTY_BITS'(place(PH_V, nmin, nmax, nmid));
        adj_duty_w = DUTY_BITS'(place(PH_W, nmin, nmax, nmid));
        shift_u    = SHIFT_BITS'(place(PH_U, shmin, shmax, shmid));
        shift_v    = SHIFT_BITS'(place(PH_V, shmin, shmax, shmid));
        shift_w    = SHIFT_BITS'(place(PH_W, shmin, shmax, shmid));
    end

    assign trigger_first  = tsum_first[DUTY_BITS-1:0] & TMASK;
    assign trigger_second = tsum_second[DUTY_BITS-1:0] & TMASK;
    assign window_mode    = mode;

endmodule

@@ sv/ssps_recon.sv @@
// ============================================================================
// ssps_recon
// Offset removal and three-phase current rebuild from two shunt samples.
// ============================================================================
module ssps_recon (
    input  ssps_pkg::adc_t   adc_first,
    input  ssps_pkg::adc_t   adc_second,
    input  ssps_pkg::adc_t   current_offset,
    input  logic [2:0]       sector_prev,
    input  logic [1:0]       mode_prev,
    output ssps_pkg::cur_t   current_u,
    output ssps_pkg::cur_t   current_v,
    output ssps_pkg::cur_t   current_w
);
    import ssps_pkg::*;

    logic signed [ADC_BITS:0] a;
    logic signed [ADC_BITS:0] b;
    cur_t                     neg_a;
    cur_t                     b_ext;
    cur_t                     a_minus_b;
    logic                     sector_ok;
    phase_t                   pf;
    phase_t                   ps;

    assign a = $signed({1'b0, adc_first}) - $signed({1'b0, current_offset});
    assign b = $signed({1'b0, adc_second}) - $signed({1'b0, current_offset});

    assign neg_a     = -CUR_BITS'(a);
    assign b_ext     = CUR_BITS'(b);
    assign a_minus_b = CUR_BITS'(a) - CUR_BITS'(b);

    assign sector_ok = (sector_prev != 3'd0) && (sector_prev != 3'd7);
    assign pf        = rd_first(sector_prev);
    assign ps        = rd_second(sector_prev);

    function automatic cur_t rebuild(input phase_t p);
        cur_t r;
        r = '0;
        if (sector_ok)
        begin
            unique case (mode_prev)
                WIN_BOTH:   r = (p == pf) ? neg_a : ((p == ps) ? b_ext : a_minus_b);
                WIN_FIRST:  r = (p == pf) ? neg_a : '0;
                WIN_SECOND: r = (p == ps) ? b_ext : '0;
                default:    r = '0;
            endcase
        end
        return r;
    endfunction

    always_comb
    begin
        current_u = rebuild(PH_U);
        current_v = rebuild(PH_V);
        current_w = rebuild(PH_W);
    end

endmodule

@@ sv/single_shunt_phase_shift_sampler_unit.sv @@
// ============================================================================
// single_shunt_phase_shift_sampler_unit
// Single-shunt current sampler with PWM phase shift, top level.
// ============================================================================
// Input stream s_*: s_tuser selects the item kind (0 PWM update, 1 ADC
// sample pair). A PWM update returns adjusted duties, per-phase shifts, two
// ADC trigger points and the window mode; a sample item returns the three
// phase currents rebuilt from the sector and mode left by earlier items.
// Output stream m_*: one result item per input item, in order.
// Config port cfg_*: register index and data; always ready. The user must
// write it only while the block holds no item; the block does not enforce it.
// Path: an item accepted on s_* goes into the input register, through the
// single compute stage, and into the result register that drives m_*.
// Throughput: one item per cycle while m_tready takes each result.
// Stall: a waiting result holds in the result register; one more item is
// still taken into the input register, after which s_tready drops until
// the result is taken.
// Reset: both registers empty, mode and sector history cleared, config
// registers at period 4000, delay 200, window 400, offset 2048.
module single_shunt_phase_shift_sampler_unit #(
    parameter int EDGE_WIDTH = 50,
    parameter int TIMER_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sector, duty_u, duty_v, duty_w, adc_first, adc_second, zero pad
    input  logic [79:0]  s_tdata,
    // func
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // adj_duty_u, adj_duty_v, adj_duty_w, shift_u, shift_v, shift_w,
    // trigger_first, trigger_second, window_mode, current_u, current_v,
    // current_w, zero pad
    output logic [175:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import ssps_pkg::*;

    `include "assert_macros.svh"

    logic        in_valid_reg;
    logic        in_func_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    logic [15:0] pwm_period_reg;
    logic [15:0] sample_delay_reg;
    logic [15:0] min_window_reg;
    adc_t        current_offset_reg;

    logic [1:0]  mode_now_reg;
    logic [1:0]  mode_prev_reg;
    logic [2:0]  sector_prev_reg;

    logic        advance;
    logic        in_load;
    logic        cfg_write;

    duty_t       p_adj_u, p_adj_v, p_adj_w;
    shift_t      p_sh_u, p_sh_v, p_sh_w;
    duty_t       p_trig1, p_trig2;
    logic [1:0]  p_mode;
    cur_t        r_cur_u, r_cur_v, r_cur_w;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_load   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_item_reg;

    ssps_pwm_calc #(
        .EDGE_WIDTH (EDGE_WIDTH),
        .TIMER_BITS (TIMER_BITS)
    ) u_pwm (
        .sector         (in_item_reg.sector),
        .duty_u         (in_item_reg.duty_u),
        .duty_v         (in_item_reg.duty_v),
        .duty_w         (in_item_reg.duty_w),
        .pwm_period     (pwm_period_reg),
        .sample_delay   (sample_delay_reg),
        .min_window     (min_window_reg),
        .adj_duty_u     (p_adj_u),
        .adj_duty_v     (p_adj_v),
        .adj_duty_w     (p_adj_w),
        .shift_u        (p_sh_u),
        .shift_v        (p_sh_v),
        .shift_w        (p_sh_w),
        .trigger_first  (p_trig1),
        .trigger_second (p_trig2),
        .window_mode    (p_mode)
    );

    ssps_recon u_recon (
        .adc_first      (in_item_reg.adc_first),
        .adc_second     (in_item_reg.adc_second),
        .current_offset (current_offset_reg),
        .sector_prev    (sector_prev_reg),
        .mode_prev      (mode_prev_reg),
        .current_u      (r_cur_u),
        .current_v      (r_cur_v),
        .current_w      (r_cur_w)
    );

    always_comb
    begin
        out_item_next = '0;
        if (in_func_reg == FUNC_PWM)
        begin
            out_item_next.adj_duty_u     = p_adj_u;
            out_item_next.adj_duty_v     = p_adj_v;
            out_item_next.adj_duty_w     = p_adj_w;
            out_item_next.shift_u        = p_sh_u;
            out_item_next.shift_v        = p_sh_v;
            out_item_next.shift_w        = p_sh_w;
            out_item_next.trigger_first  = p_trig1;
            out_item_next.trigger_second = p_trig2;
            out_item_next.window_mode    = p_mode;
        end
        else
        begin
            out_item_next.current_u = r_cur_u;
            out_item_next.current_v = r_cur_v;
            out_item_next.current_w = r_cur_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mode_now_reg       <= '0;
            mode_prev_reg      <= '0;
            sector_prev_reg    <= '0;
            pwm_period_reg     <= 16'd4000;
            sample_delay_reg   <= 16'd200;
            min_window_reg     <= 16'd400;
            current_offset_reg <= 12'd2048;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                if (in_func_reg == FUNC_PWM)
                begin
                    mode_prev_reg <= mode_now_reg;
                    mode_now_reg  <= p_mode;
                end
                else
                begin
                    sector_prev_reg <= in_item_reg.sector;
                end
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_PWM_PERIOD:     pwm_period_reg     <= cfg_data;
                    CFG_SAMPLE_DELAY:   sample_delay_reg   <= cfg_data;
                    CFG_MIN_WINDOW:     min_window_reg     <= cfg_data;
                    CFG_CURRENT_OFFSET: current_offset_reg <= cfg_data[ADC_BITS-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= in_item_t'(s_tdata);
            in_func_reg <= s_tuser;
        end
        if (advance)
            out_item_reg <= out_item_next;
    end

    `ASSERT_CLK(a_ready_when_empty, clk, rst_n,
        !in_valid_reg |-> s_tready,
        "ready low with empty input register")
    `ASSERT_CLK(a_result_kinds_exclusive, clk, rst_n,
        (out_valid_reg && out_item_reg.window_mode != WIN_NONE) |->
        (out_item_reg.current_u == '0 && out_item_reg.current_v == '0 &&
        out_item_reg.current_w == '0),
        "PWM result carries currents")
    `ASSERT_CLK(a_pwm_mode_history, clk, rst_n,
        (advance && in_func_reg == FUNC_PWM) |=>
        (mode_prev_reg == $past(mode_now_reg) && mode_now_reg == out_item_reg.window_mode),
        "mode history not shifted on PWM update")
    `ASSERT_CLK(a_sample_keeps_mode, clk, rst_n,
        (advance && in_func_reg == FUNC_SAMPLE) |=>
        ($stable(mode_now_reg) && $stable(mode_prev_reg) &&
        sector_prev_reg == $past(in_item_reg.sector)),
        "sample item disturbed mode or sector history")

endmodule

@@ sim/single_shunt_phase_shift_sampler_unit_tb.sv @@
// ============================================================================
// single_shunt_phase_shift_sampler_unit_tb
// Self-checking bench for the single-shunt phase-shift sampler. A short
// directed table runs first, then paced random PWM/sample traffic under
// several register settings. Results are compared field by field with an
// in-bench model of the shift rules and current rebuild, or typed values.
// ============================================================================
`timescale 1ns / 100ps

module single_shunt_phase_shift_sampler_unit_tb;

    import ssps_pkg::*;

    localparam int EDGE_TICKS = 50;
    localparam int DIR_ROWS   = 23;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    // bench copy of the block's registers and history
    logic [15:0] cfg_period;
    logic [15:0] cfg_delay;
    logic [15:0] cfg_window;
    logic [11:0] cfg_offset;
    logic [1:0]  hist_mode_now;
    logic [1:0]  hist_mode_prev;
    logic [2:0]  hist_sector;

    out_item_t sampler_results_due [$];
    logic      typed_on;
    out_item_t typed_result;

    int mismatches      = 0;
    int results_checked = 0;
    int pwm_sent        = 0;
    int sample_sent     = 0;
    int settings_used   = 1;
    int burst_left      = 0;

    logic       stim_last_func   = FUNC_SAMPLE;
    logic [2:0] stim_last_sector = 3'd1;

    // phase index per sector: max, min, mid duty; read at trigger 1 and 2
    phase_t max_phase_tab [8] = '{PH_U, PH_U, PH_V, PH_V, PH_W, PH_W, PH_U, PH_U};
    phase_t min_phase_tab [8] = '{PH_V, PH_W, PH_W, PH_U, PH_U, PH_V, PH_V, PH_V};
    phase_t mid_phase_tab [8] = '{PH_W, PH_V, PH_U, PH_W, PH_V, PH_U, PH_W, PH_W};
    phase_t rd1_phase_tab [8] = '{PH_U, PH_W, PH_W, PH_U, PH_U, PH_V, PH_V, PH_U};
    phase_t rd2_phase_tab [8] = '{PH_U, PH_U, PH_V, PH_V, PH_W, PH_W, PH_U, PH_U};

    typedef struct packed {
        logic        typed;
        logic        func;
        logic [2:0]  sector;
        logic [15:0] duty_u;
        logic [15:0] duty_v;
        logic [15:0] duty_w;
        logic [11:0] adc_first;
        logic [11:0] adc_second;
    } stim_row_t;

    stim_row_t stim_table [DIR_ROWS] = '{
        '{1'b1, FUNC_SAMPLE, 3'd3, 16'd0,     16'd0,     16'd0,     12'd4095, 12'd0},
        '{1'b1, FUNC_PWM,    3'd1, 16'd0,     16'd0,     16'd0,     12'd0,    12'd0},
        '{1'b1, FUNC_SAMPLE, 3'd1, 16'd0,     16'd0,     16'd0,     12'd0,    12'd4095},
        '{1'b0, FUNC_PWM,    3'd1, 16'd3000,  16'd1500,  16'd100,   12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd2, 16'd0,     16'd0,     16'd0,     12'd4095, 12'd4095},
        '{1'b0, FUNC_PWM,    3'd2, 16'd2500,  16'd3990,  16'd30,    12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd3, 16'd0,     16'd0,     16'd0,     12'd0,    12'd0},
        '{1'b0, FUNC_PWM,    3'd3, 16'd10,    16'd65535, 16'd2100,  12'd4095, 12'd4095},
        '{1'b0, FUNC_SAMPLE, 3'd4, 16'd65535, 16'd65535, 16'd65535, 12'd2048, 12'd2048},
        '{1'b0, FUNC_PWM,    3'd4, 16'd500,   16'd1000,  16'd1900,  12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd5, 16'd0,     16'd0,     16'd0,     12'd100,  12'd3000},
        '{1'b0, FUNC_PWM,    3'd5, 16'd65535, 16'd0,     16'd4000,  12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd6, 16'd0,     16'd0,     16'd0,     12'd4095, 12'd1},
        '{1'b0, FUNC_PWM,    3'd6, 16'd3999,  16'd2000,  16'd2001,  12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd7, 16'd0,     16'd0,     16'd0,     12'd1234, 12'd2222},
        '{1'b0, FUNC_PWM,    3'd0, 16'd1000,  16'd200,   16'd3000,  12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd0, 16'd0,     16'd0,     16'd0,     12'd3000, 12'd1000},
        '{1'b0, FUNC_PWM,    3'd7, 16'd65535, 16'd65535, 16'd0,     12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd1, 16'd0,     16'd0,     16'd0,     12'd2047, 12'd2049},
        '{1'b0, FUNC_PWM,    3'd6, 16'd4000,  16'd50,    16'd1950,  12'd0,    12'd0},
        '{1'b0, FUNC_SAMPLE, 3'd2, 16'd0,     16'd0,     16'd0,     12'd0,    12'd4095},
        '{1'b0, FUNC_PWM,    3'd4, 16'd43690, 16'd21845, 16'd32768, 12'd2730, 12'd1365},
        '{1'b0, FUNC_SAMPLE, 3'd5, 16'd21845, 16'd43690, 16'd0,     12'd1365, 12'd2730}
    };

    single_shunt_phase_shift_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shift rules for a PWM update, current rebuild for a sample item
    function automatic out_item_t sampler_response(input logic func, input in_item_t it);
        out_item_t  r;
        int         d [3];
        int         sh [3];
        int         cur [3];
        int         per;
        int         half;
        int         a;
        int         b;
        int         pmax;
        int         pmin;
        int         pmid;
        int         pf;
        int         ps;
        logic [1:0] win;
        logic [2:0] s;
        r   = '0;
        sh  = '{0, 0, 0};
        cur = '{0, 0, 0};
        win = WIN_NONE;
        if (func == FUNC_PWM)
        begin
            s    = it.sector;
            pmax = int'(max_phase_tab[s]);
            pmin = int'(min_phase_tab[s]);
            pmid = int'(mid_phase_tab[s]);
            per  = int'(cfg_period);
            half = per / 2;
            d[0] = int'(it.duty_u);
            d[1] = int'(it.duty_v);
            d[2] = int'(it.duty_w);
            hist_mode_prev = hist_mode_now;
            if (EDGE_TICKS < d[pmin])
            begin
                sh[pmin] = EDGE_TICKS - d[pmin];
                d[pmin] += sh[pmin];
            end
            if (d[pmax] <= half)
                sh[pmax] = d[pmax] - EDGE_TICKS;
            else if (per - EDGE_TICKS > d[pmax])
            begin
                sh[pmax] = per - EDGE_TICKS - d[pmax];
                d[pmax] += sh[pmax];
            end
            if (d[pmid] <= half)
            begin
                win = WIN_SECOND;
                sh[pmid] = (half - d[pmid] < d[pmid]) ? half - d[pmid] : d[pmid];
                d[pmid] += sh[pmid];
                if (d[pmid] - d[pmin] > int'(cfg_window))
                    win |= WIN_FIRST;
            end
            else
            begin
                win = WIN_FIRST;
                if (d[pmid] - half < per - d[pmid])
                    sh[pmid] = half - d[pmid];
                else
                    sh[pmid] = d[pmid] - per;
                d[pmid] += sh[pmid];
                if (d[pmax] - d[pmid] > int'(cfg_window))
                    win |= WIN_SECOND;
            end
            hist_mode_now    = win;
            r.adj_duty_u     = 16'(d[0]);
            r.adj_duty_v     = 16'(d[1]);
            r.adj_duty_w     = 16'(d[2]);
            r.shift_u        = 17'(sh[0]);
            r.shift_v        = 17'(sh[1]);
            r.shift_w        = 17'(sh[2]);
            r.trigger_first  = 16'(d[pmin] + int'(cfg_delay));
            r.trigger_second = 16'(d[pmid] + int'(cfg_delay));
            r.window_mode    = win;
        end
        else
        begin
            a = int'(it.adc_first) - int'(cfg_offset);
            b = int'(it.adc_second) - int'(cfg_offset);
            if (hist_sector >= 3'd1 && hist_sector <= 3'd6)
            begin
                pf = int'(rd1_phase_tab[hist_sector]);
                ps = int'(rd2_phase_tab[hist_sector]);
                case (hist_mode_prev)
                    WIN_BOTH:
                    begin
                        cur[pf]          = -a;
                        cur[ps]          = b;
                        cur[3 - pf - ps] = a - b;
                    end
                    WIN_FIRST:  cur[pf] = -a;
                    WIN_SECOND: cur[ps] = b;
                    default: ;
                endcase
            end
            hist_sector = it.sector;
            r.current_u = 14'(cur[0]);
            r.current_v = 14'(cur[1]);
            r.current_w = 14'(cur[2]);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // registers and input items as the block takes them
    always @(posedge clk)
    begin : accept_mon
        out_item_t predicted;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PWM_PERIOD:     cfg_period = cfg_data;
                    CFG_SAMPLE_DELAY:   cfg_delay  = cfg_data;
                    CFG_MIN_WINDOW:     cfg_window = cfg_data;
                    CFG_CURRENT_OFFSET: cfg_offset = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predicted = sampler_response(s_tuser, in_item_t'(s_tdata));
                sampler_results_due.push_back(typed_on ? typed_result : predicted);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        out_item_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_item_t'(m_tdata);
            if (sampler_results_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = sampler_results_due.pop_front();
                results_checked++;
                compare_field("adj_duty_u", want.adj_duty_u, got.adj_duty_u);
                compare_field("adj_duty_v", want.adj_duty_v, got.adj_duty_v);
                compare_field("adj_duty_w", want.adj_duty_w, got.adj_duty_w);
                compare_field("shift_u", want.shift_u, got.shift_u);
                compare_field("shift_v", want.shift_v, got.shift_v);
                compare_field("shift_w", want.shift_w, got.shift_w);
                compare_field("trigger_first", want.trigger_first, got.trigger_first);
                compare_field("trigger_second", want.trigger_second, got.trigger_second);
                compare_field("window_mode", want.window_mode, got.window_mode);
                compare_field("current_u", want.current_u, got.current_u);
                compare_field("current_v", want.current_v, got.current_v);
                compare_field("current_w", want.current_w, got.current_w);
            end
        end
    end

    // receiver: full rate, light stalls, fixed pattern, heavy stalls
    logic [15:0] stall_pat   = 16'b1101_1000_1110_0110;
    logic [9:0]  ready_phase = '0;

    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_phase[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= stall_pat[ready_phase[3:0]];
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_item(input logic func, input in_item_t it, input logic typed,
                             input out_item_t typed_val);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid     <= 1'b1;
        s_tuser      <= func;
        s_tdata      <= it;
        typed_on     <= typed;
        typed_result <= typed_val;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        stim_last_func = func;
        if (func == FUNC_PWM)
        begin
            pwm_sent++;
            stim_last_sector = it.sector;
        end
        else
            sample_sent++;
    endtask

    task automatic wait_all_results();
        int waited;
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        for (waited = 0; waited < 5000 && sampler_results_due.size() != 0; waited++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sampler_results_due.size() != 0)
        begin
            mismatches += sampler_results_due.size();
            $display("%0t: %0d results never arrived", $time, sampler_results_due.size());
            sampler_results_due.delete();
        end
    endtask

    task automatic load_registers(input logic [15:0] period, input logic [15:0] delay,
                                  input logic [15:0] window, input logic [15:0] offset);
        logic [1:0]  reg_ids [4];
        logic [15:0] vals [4];
        reg_ids = '{CFG_PWM_PERIOD, CFG_SAMPLE_DELAY, CFG_MIN_WINDOW, CFG_CURRENT_OFFSET};
        vals    = '{period, delay, window, offset};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] random_duty(input int per);
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1:
                case ($urandom_range(0, 5))
                    0:       return 16'd0;
                    1:       return 16'hFFFF;
                    2:       return 16'(EDGE_TICKS);
                    3:       return 16'(per / 2);
                    4:       return 16'(per - EDGE_TICKS);
                    default: return 16'(per);
                endcase
            default: return 16'($urandom_range(0, per));
        endcase
    endfunction

    function automatic logic [11:0] random_adc();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
        return 12'($urandom_range(0, 4095));
    endfunction

    // duties mostly ordered as the sector says, otherwise left as drawn
    function automatic in_item_t random_item(input logic [2:0] sec, input int per);
        in_item_t    it;
        logic [15:0] v [3];
        logic [15:0] w [3];
        logic [15:0] t;
        it = '0;
        for (int i = 0; i < 3; i++)
            v[i] = random_duty(per);
        if ($urandom_range(0, 9) < 7)
        begin
            if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
            if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
            if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
            w[int'(min_phase_tab[sec])] = v[0];
            w[int'(mid_phase_tab[sec])] = v[1];
            w[int'(max_phase_tab[sec])] = v[2];
        end
        else
            w = v;
        it.sector     = sec;
        it.duty_u     = w[0];
        it.duty_v     = w[1];
        it.duty_w     = w[2];
        it.adc_first  = random_adc();
        it.adc_second = random_adc();
        return it;
    endfunction

    // mostly PWM update / sample pairs, some noise in kind and sector
    task automatic run_random_items(input int count, input int per);
        logic       func;
        logic [2:0] sec;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_all_results();
            if ($urandom_range(0, 4) == 0)
                func = 1'($urandom_range(0, 1));
            else
                func = (stim_last_func == FUNC_PWM) ? FUNC_SAMPLE : FUNC_PWM;
            if (func == FUNC_PWM || $urandom_range(0, 4) == 0)
                sec = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 6));
            else
                sec = stim_last_sector;
            send_item(func, random_item(sec, per), 1'b0, '0);
        end
    endtask

    initial
    begin
        stim_row_t  row;
        in_item_t   it;
        out_item_t  typed_val;
        logic [15:0] r_period;
        cfg_period     = 16'd4000;
        cfg_delay      = 16'd200;
        cfg_window     = 16'd400;
        cfg_offset     = 12'd2048;
        hist_mode_now  = WIN_NONE;
        hist_mode_prev = WIN_NONE;
        hist_sector    = 3'd0;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= FUNC_PWM;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_PWM_PERIOD;
        cfg_data     <= '0;
        typed_on     <= 1'b0;
        typed_result <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row           = stim_table[r];
            it            = '0;
            it.sector     = row.sector;
            it.duty_u     = row.duty_u;
            it.duty_v     = row.duty_v;
            it.duty_w     = row.duty_w;
            it.adc_first  = row.adc_first;
            it.adc_second = row.adc_second;
            typed_val     = '0;
            // zero duties at reset settings: max parked below half, mid untouched
            if (r == 1)
            begin
                typed_val.shift_u        = -17'sd50;
                typed_val.trigger_first  = 16'd200;
                typed_val.trigger_second = 16'd200;
                typed_val.window_mode    = WIN_SECOND;
            end
            send_item(row.func, it, row.typed, typed_val);
        end

        run_random_items(221, 4000);

        wait_all_results();
        load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0FFF);
        run_random_items(221, 65535);

        wait_all_results();
        load_registers(16'd1, 16'd0, 16'd0, 16'd0);
        run_random_items(221, 1);

        wait_all_results();
        load_registers(16'd20000, 16'd1000, 16'd2000, 16'd1000);
        run_random_items(221, 20000);

        wait_all_results();
        r_period = 16'($urandom_range(1, 65535));
        load_registers(r_period, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4095)));
        run_random_items(221, int'(r_period));

        // period below the edge width, trigger sums wrapping
        wait_all_results();
        load_registers(16'd49, 16'd65000, 16'd10, 16'd2047);
        run_random_items(221, 49);

        wait_all_results();
        $display("Sent %0d PWM updates and %0d sample items under %0d register settings,",
                 pwm_sent, sample_sent, settings_used);
        $display("compared %0d results field by field; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", sampler_results_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
